// File: hw/rtl/complex_phasor_tone_generator_unit_defines.svh
// Assertion macros for the complex phasor tone generator.
// Each macro expects clk and rst_n in scope at the place of use.
`ifndef COMPLEX_PHASOR_TONE_GENERATOR_UNIT_DEFINES_SVH
`define COMPLEX_PHASOR_TONE_GENERATOR_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CPTG_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cptg: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define CPTG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cptg: next-cycle check failed");

`endif

// File: hw/rtl/cptg_pkg.sv
// Shared constants, types and fixed-point helpers for the phasor tone generator.
// No dependencies; all other RTL files but the macro header use this package by scoped name.
`default_nettype none

package cptg_pkg;

  localparam int WORD_W    = 32;
  localparam int FRAC_BITS = 30;
  localparam int MAX_BURST = 64;
  localparam int COUNT_W   = 7;
  localparam int CNT_W     = $clog2(MAX_BURST + 1);
  localparam int PROD_W    = 2 * WORD_W;
  localparam int SHR_W     = PROD_W - FRAC_BITS;
  localparam int ACC_W     = ((SHR_W > FRAC_BITS + 2) ? SHR_W : FRAC_BITS + 2) + 2;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = PADDR_W - 2;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  // 1.0 and 3.0 in the fixed-point format
  localparam word_t UNIT_Q  = WORD_W'(64'd1 << FRAC_BITS);
  localparam acc_t  THREE_Q = ACC_W'(3) << FRAC_BITS;

  // Register map, indexed by paddr word offset
  typedef enum logic [REG_IDX_W-1:0] {
    REG_RATE_RE = 2'd0,
    REG_RATE_IM = 2'd1,
    REG_INIT_RE = 2'd2,
    REG_INIT_IM = 2'd3
  } reg_idx_t;

  // Datapath steps issued by the controller
  typedef enum logic [3:0] {
    DP_HOLD,
    DP_EMIT,
    DP_ROT0,
    DP_ROT1,
    DP_ROT2,
    DP_ROT3,
    DP_ROT4,
    DP_REN0,
    DP_REN1,
    DP_REN2,
    DP_REN3,
    DP_REN4,
    DP_REN5
  } dp_step_t;

  typedef struct packed {
    dp_step_t step;
    logic     last;
  } dp_cmd_t;

  // Arithmetic shift right of a full product, widened to the accumulator
  function automatic acc_t fshift(input prod_t p);
    return ACC_W'(p >>> FRAC_BITS);
  endfunction

  // Saturate an accumulator value to the word range
  function automatic word_t sat(input acc_t v);
    word_t res;
    if ((&v[ACC_W-1:WORD_W-1]) || !(|v[ACC_W-1:WORD_W-1])) begin
      res = v[WORD_W-1:0];
    end else if (v[ACC_W-1]) begin
      res = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(WORD_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/cptg_channels.sv
// Valid/ready channel interfaces: burst requests in, phasor samples out.
// Depends on cptg_pkg for field widths.
`default_nettype none

interface cptg_in_if;
  logic                         valid;
  logic                         ready;
  logic [cptg_pkg::COUNT_W-1:0] sample_count;

  modport source (output valid, output sample_count, input ready);
  modport sink   (input valid, input sample_count, output ready);
endinterface

interface cptg_out_if;
  logic                valid;
  logic                ready;
  cptg_pkg::word_t     sample_re;
  cptg_pkg::word_t     sample_im;
  logic                last_sample;

  modport source (output valid, output sample_re, output sample_im, output last_sample,
                  input ready);
  modport sink   (input valid, input sample_re, input sample_im, input last_sample,
                  output ready);
endinterface

`default_nettype wire

// File: hw/rtl/cptg_regs.sv
// APB-style configuration registers: rotation rate and initial phase.
// Depends on cptg_pkg; raises a one-cycle phasor reload after an init write.
`default_nettype none

module cptg_regs (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [cptg_pkg::PADDR_W-1:0] paddr,
  input  wire logic [cptg_pkg::PDATA_W-1:0] pwdata,
  output      logic [cptg_pkg::PDATA_W-1:0] prdata,
  output      logic                         pready,
  output      cptg_pkg::word_t              rate_re,
  output      cptg_pkg::word_t              rate_im,
  output      cptg_pkg::word_t              init_re,
  output      cptg_pkg::word_t              init_im,
  output      logic                         load_phasor
);

  cptg_pkg::word_t    rate_re_r, rate_im_r, init_re_r, init_im_r;
  logic               load_r;
  logic               wr_en;
  cptg_pkg::reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = cptg_pkg::reg_idx_t'(paddr[cptg_pkg::PADDR_W-1:2]);

  // Store written registers; flag a reload on an init write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_re_r <= cptg_pkg::UNIT_Q;
      rate_im_r <= '0;
      init_re_r <= cptg_pkg::UNIT_Q;
      init_im_r <= '0;
      load_r    <= 1'b0;
    end else begin
      load_r <= 1'b0;
      if (wr_en) begin
        case (idx)
          cptg_pkg::REG_RATE_RE: rate_re_r <= pwdata;
          cptg_pkg::REG_RATE_IM: rate_im_r <= pwdata;
          cptg_pkg::REG_INIT_RE: begin
            init_re_r <= pwdata;
            load_r    <= 1'b1;
          end
          cptg_pkg::REG_INIT_IM: begin
            init_im_r <= pwdata;
            load_r    <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // Read back
  always_comb begin
    case (idx)
      cptg_pkg::REG_RATE_RE: prdata = rate_re_r;
      cptg_pkg::REG_RATE_IM: prdata = rate_im_r;
      cptg_pkg::REG_INIT_RE: prdata = init_re_r;
      cptg_pkg::REG_INIT_IM: prdata = init_im_r;
      default:               prdata = '0;
    endcase
  end

  assign rate_re     = rate_re_r;
  assign rate_im     = rate_im_r;
  assign init_re     = init_re_r;
  assign init_im     = init_im_r;
  assign load_phasor = load_r;

endmodule

`default_nettype wire

// File: hw/rtl/cptg_ctrl.sv
// Sequencer for the tone generator: burst counting, sample parity and the
// step schedule of the shared-multiplier datapath. Depends on cptg_pkg.
`default_nettype none

module cptg_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output      logic                         in_ready,
  input  wire logic [cptg_pkg::COUNT_W-1:0] in_sample_count,
  output      logic                         out_valid,
  input  wire logic                         out_ready,
  input  wire logic                         load_phasor,
  output      cptg_pkg::dp_cmd_t            cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EMIT,
    ST_ROT0,
    ST_ROT1,
    ST_ROT2,
    ST_ROT3,
    ST_ROT4,
    ST_REN0,
    ST_REN1,
    ST_REN2,
    ST_REN3,
    ST_REN4,
    ST_REN5
  } state_t;

  state_t                     state_r, state_nxt;
  logic [cptg_pkg::CNT_W-1:0] remaining_r, remaining_nxt;
  logic                       parity_r, parity_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_free;
  logic                       last_one;

  assign out_free = !out_valid_r || out_ready;
  assign last_one = (remaining_r == cptg_pkg::CNT_W'(1));

  always_comb begin
    state_nxt     = state_r;
    remaining_nxt = remaining_r;
    parity_nxt    = parity_r;
    out_valid_nxt = out_valid_r;
    cmd.step      = cptg_pkg::DP_HOLD;
    cmd.last      = last_one;

    // drop the output flag once the sample is taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid && (in_sample_count != '0)) begin
          if (32'(in_sample_count) > 32'(cptg_pkg::MAX_BURST)) begin
            remaining_nxt = cptg_pkg::CNT_W'(cptg_pkg::MAX_BURST);
          end else begin
            remaining_nxt = cptg_pkg::CNT_W'(in_sample_count);
          end
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.step      = cptg_pkg::DP_EMIT;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_ROT0;
        end
      end
      ST_ROT0: begin
        cmd.step  = cptg_pkg::DP_ROT0;
        state_nxt = ST_ROT1;
      end
      ST_ROT1: begin
        cmd.step  = cptg_pkg::DP_ROT1;
        state_nxt = ST_ROT2;
      end
      ST_ROT2: begin
        cmd.step  = cptg_pkg::DP_ROT2;
        state_nxt = ST_ROT3;
      end
      ST_ROT3: begin
        cmd.step  = cptg_pkg::DP_ROT3;
        state_nxt = ST_ROT4;
      end
      ST_ROT4: begin
        cmd.step   = cptg_pkg::DP_ROT4;
        parity_nxt = !parity_r;
        if (parity_r) begin
          state_nxt = ST_REN0;
        end else begin
          remaining_nxt = remaining_r - cptg_pkg::CNT_W'(1);
          state_nxt     = last_one ? ST_IDLE : ST_EMIT;
        end
      end
      ST_REN0: begin
        cmd.step  = cptg_pkg::DP_REN0;
        state_nxt = ST_REN1;
      end
      ST_REN1: begin
        cmd.step  = cptg_pkg::DP_REN1;
        state_nxt = ST_REN2;
      end
      ST_REN2: begin
        cmd.step  = cptg_pkg::DP_REN2;
        state_nxt = ST_REN3;
      end
      ST_REN3: begin
        cmd.step  = cptg_pkg::DP_REN3;
        state_nxt = ST_REN4;
      end
      ST_REN4: begin
        cmd.step  = cptg_pkg::DP_REN4;
        state_nxt = ST_REN5;
      end
      ST_REN5: begin
        cmd.step      = cptg_pkg::DP_REN5;
        remaining_nxt = remaining_r - cptg_pkg::CNT_W'(1);
        state_nxt     = last_one ? ST_IDLE : ST_EMIT;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // an init write restarts the parity count
    if (load_phasor) begin
      parity_nxt = 1'b0;
    end
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      remaining_r <= '0;
      parity_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      remaining_r <= remaining_nxt;
      parity_r    <= parity_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// File: hw/rtl/cptg_dp.sv
// Datapath: phasor registers, one shared 32x32 multiplier with a product
// register, accumulator and output sample register. Depends on cptg_pkg.
`default_nettype none

module cptg_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cptg_pkg::dp_cmd_t cmd,
  input  wire logic              load_phasor,
  input  wire cptg_pkg::word_t   rate_re,
  input  wire cptg_pkg::word_t   rate_im,
  input  wire cptg_pkg::word_t   init_re,
  input  wire cptg_pkg::word_t   init_im,
  output      cptg_pkg::word_t   sample_re,
  output      cptg_pkg::word_t   sample_im,
  output      logic              last_sample
);

  cptg_pkg::word_t phasor_re_r, phasor_re_nxt;
  cptg_pkg::word_t phasor_im_r, phasor_im_nxt;
  cptg_pkg::prod_t prod_r, prod_nxt;
  cptg_pkg::acc_t  acc_r, acc_nxt;
  cptg_pkg::word_t tmp_r, tmp_nxt;
  cptg_pkg::word_t d_r, d_nxt;
  cptg_pkg::word_t sample_re_r, sample_re_nxt;
  cptg_pkg::word_t sample_im_r, sample_im_nxt;
  logic            last_r, last_nxt;
  cptg_pkg::word_t mul_a, mul_b;
  cptg_pkg::acc_t  sh;

  assign sh = cptg_pkg::fshift(prod_r);

  // Select multiplier operands for the current step
  always_comb begin
    case (cmd.step)
      cptg_pkg::DP_ROT0: begin mul_a = phasor_re_r; mul_b = rate_re;     end
      cptg_pkg::DP_ROT1: begin mul_a = phasor_im_r; mul_b = rate_im;     end
      cptg_pkg::DP_ROT2: begin mul_a = phasor_re_r; mul_b = rate_im;     end
      cptg_pkg::DP_ROT3: begin mul_a = phasor_im_r; mul_b = rate_re;     end
      cptg_pkg::DP_REN0: begin mul_a = phasor_re_r; mul_b = phasor_re_r; end
      cptg_pkg::DP_REN1: begin mul_a = phasor_im_r; mul_b = phasor_im_r; end
      cptg_pkg::DP_REN3: begin mul_a = phasor_re_r; mul_b = d_r;         end
      cptg_pkg::DP_REN4: begin mul_a = phasor_im_r; mul_b = d_r;         end
      default:           begin mul_a = phasor_re_r; mul_b = rate_re;     end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  // Accumulate, saturate and update the phasor
  always_comb begin
    phasor_re_nxt = phasor_re_r;
    phasor_im_nxt = phasor_im_r;
    acc_nxt       = acc_r;
    tmp_nxt       = tmp_r;
    d_nxt         = d_r;
    sample_re_nxt = sample_re_r;
    sample_im_nxt = sample_im_r;
    last_nxt      = last_r;

    case (cmd.step)
      cptg_pkg::DP_EMIT: begin
        sample_re_nxt = phasor_re_r;
        sample_im_nxt = phasor_im_r;
        last_nxt      = cmd.last;
      end
      cptg_pkg::DP_ROT1: acc_nxt = sh;
      cptg_pkg::DP_ROT2: tmp_nxt = cptg_pkg::sat(acc_r - sh);
      cptg_pkg::DP_ROT3: acc_nxt = sh;
      cptg_pkg::DP_ROT4: begin
        phasor_re_nxt = tmp_r;
        phasor_im_nxt = cptg_pkg::sat(acc_r + sh);
      end
      cptg_pkg::DP_REN1: acc_nxt = sh;
      cptg_pkg::DP_REN2: d_nxt = cptg_pkg::sat((cptg_pkg::THREE_Q - (acc_r + sh)) >>> 1);
      cptg_pkg::DP_REN4: phasor_re_nxt = cptg_pkg::sat(sh);
      cptg_pkg::DP_REN5: phasor_im_nxt = cptg_pkg::sat(sh);
      default: ;
    endcase

    // reload from the init registers after an init write
    if (load_phasor) begin
      phasor_re_nxt = init_re;
      phasor_im_nxt = init_im;
    end
  end

  // Phasor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phasor_re_r <= cptg_pkg::UNIT_Q;
      phasor_im_r <= '0;
    end else begin
      phasor_re_r <= phasor_re_nxt;
      phasor_im_r <= phasor_im_nxt;
    end
  end

  // Working and output payload registers
  always_ff @(posedge clk) begin
    prod_r      <= prod_nxt;
    acc_r       <= acc_nxt;
    tmp_r       <= tmp_nxt;
    d_r         <= d_nxt;
    sample_re_r <= sample_re_nxt;
    sample_im_r <= sample_im_nxt;
    last_r      <= last_nxt;
  end

  assign sample_re   = sample_re_r;
  assign sample_im   = sample_im_r;
  assign last_sample = last_r;

endmodule

`default_nettype wire

// File: hw/rtl/complex_phasor_tone_generator_unit.sv
// Top level of the complex phasor tone generator: register port, controller
// and datapath. Depends on cptg_pkg, cptg_channels, cptg_regs, cptg_ctrl, cptg_dp.
//
// Each request asks for a burst of 1 to 64 samples (0 gives none, more than
// 64 gives 64); the block emits the current phasor, then rotates it by the
// rate vector, and renormalizes it after every second sample. All four
// products of a rotation and the two squares and two scalings of a
// renormalization go through one shared 32x32 multiplier, one product per
// cycle: a sample steps through EMIT and ROT0 to ROT4, and then through
// REN0 to REN5 when a renormalization follows; a burst also waits on any
// stall on the result channel. One finished sample waits in the output
// register while the next is computed. A new request is taken once the
// previous burst has been computed. Writing init_re or init_im reloads the
// phasor from both init registers and restarts the renormalization count.
`default_nettype none

`include "complex_phasor_tone_generator_unit_defines.svh"

module complex_phasor_tone_generator_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  cptg_in_if.sink                           in_ch,
  cptg_out_if.source                        out_ch,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [cptg_pkg::PADDR_W-1:0] paddr,
  input  wire logic [cptg_pkg::PDATA_W-1:0] pwdata,
  output      logic [cptg_pkg::PDATA_W-1:0] prdata,
  output      logic                         pready
);

  cptg_pkg::word_t   rate_re, rate_im, init_re, init_im;
  logic              load_phasor;
  cptg_pkg::dp_cmd_t cmd;
  logic              in_ready;
  logic              out_valid;
  cptg_pkg::word_t   sample_re, sample_im;
  logic              last_sample;

  cptg_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .rate_re     (rate_re),
    .rate_im     (rate_im),
    .init_re     (init_re),
    .init_im     (init_im),
    .load_phasor (load_phasor)
  );

  cptg_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ready),
    .in_sample_count (in_ch.sample_count),
    .out_valid       (out_valid),
    .out_ready       (out_ch.ready),
    .load_phasor     (load_phasor),
    .cmd             (cmd)
  );

  cptg_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .load_phasor (load_phasor),
    .rate_re     (rate_re),
    .rate_im     (rate_im),
    .init_re     (init_re),
    .init_im     (init_im),
    .sample_re   (sample_re),
    .sample_im   (sample_im),
    .last_sample (last_sample)
  );

  // Drive the channels
  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid;
  assign out_ch.sample_re   = sample_re;
  assign out_ch.sample_im   = sample_im;
  assign out_ch.last_sample = last_sample;

  // A new sample is loaded only into a free output slot
  `CPTG_ASSERT_SAME(a_emit_slot_free, cmd.step == cptg_pkg::DP_EMIT, !out_ch.valid || out_ch.ready)
  // A nonempty burst keeps the request channel closed
  `CPTG_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready && in_ch.sample_count != '0, !in_ch.ready)
  // No datapath step runs while a request can be taken
  `CPTG_ASSERT_SAME(a_idle_no_step, in_ch.ready, cmd.step == cptg_pkg::DP_HOLD)

endmodule

`default_nettype wire

// File: verif/tb_complex_phasor_tone_generator_unit.sv
`timescale 1ns / 100ps
// Self-checking bench for the complex phasor tone generator: drives burst requests
// and register writes, predicts every phasor sample and compares on the result side.
// Depends on cptg_pkg, cptg_channels and the complex_phasor_tone_generator_unit RTL.

module tb_complex_phasor_tone_generator_unit;
  import cptg_pkg::*;

  localparam int          CYCLE_LIMIT   = 4_000_000;
  localparam int          SETTLE_CYCLES = 30;
  localparam int          PHASES        = 7;
  localparam int          PHASE_ITEMS   = 65;
  localparam int          LONG_HOLD     = 400;
  localparam word_t       MAX_Q         = 32'h7fff_ffff;
  localparam word_t       MIN_Q         = 32'h8000_0000;
  localparam word_t       NEG_UNIT_Q    = 32'hc000_0000;
  localparam longint      THREE_FIX     = longint'(3) <<< FRAC_BITS;

  typedef struct {
    word_t re;
    word_t im;
    logic  last;
  } tone_sample_t;

  typedef enum {ROW_BURST, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e        kind;
    reg_idx_t         reg_sel;
    word_t            wdata;
    logic [COUNT_W-1:0] count;
    bit               fixed;
    word_t            fix_re;
    word_t            fix_im;
  } plan_row_t;

  logic               clk;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  cptg_in_if  in_ch();
  cptg_out_if out_ch();

  complex_phasor_tone_generator_unit uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predicted register copy and phasor state
  word_t rate_re_q, rate_im_q, init_re_q, init_im_q;
  word_t phasor_re_q, phasor_im_q;
  logic  renorm_due;

  tone_sample_t expected_samples[$];
  plan_row_t    plan[$];

  int  mismatches;
  int  reg_errors;
  int  cycle_count;
  bit  calm;
  int  hold_req;
  int  hold_ack;
  int  rx_stall;
  int  rx_quiet;

  // Clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Fixed-point product, truncated toward minus infinity
  function automatic longint qmul(input word_t a, input word_t b);
    longint p;
    p = longint'(a) * longint'(b);
    return p >>> FRAC_BITS;
  endfunction

  function automatic word_t clamp_word(input longint v);
    if (v > longint'(MAX_Q)) return MAX_Q;
    if (v < longint'(MIN_Q)) return MIN_Q;
    return word_t'(v);
  endfunction

  function automatic void apply_write(input reg_idx_t sel, input word_t v);
    case (sel)
      REG_RATE_RE: rate_re_q = v;
      REG_RATE_IM: rate_im_q = v;
      REG_INIT_RE, REG_INIT_IM: begin
        if (sel == REG_INIT_RE) init_re_q = v;
        else init_im_q = v;
        phasor_re_q = init_re_q;
        phasor_im_q = init_im_q;
        renorm_due  = 1'b0;
      end
      default: ;
    endcase
  endfunction

  // Emit, rotate and (every second sample) renormalize for one burst
  function automatic void predict_tone_burst(input logic [COUNT_W-1:0] count, input bit fixed,
                                             input word_t fix_re, input word_t fix_im);
    int           n;
    tone_sample_t s;
    word_t        nr, ni, d;
    longint       mag;
    n = (count > MAX_BURST) ? MAX_BURST : count;
    for (int k = 0; k < n; k++) begin
      s.re   = fixed ? fix_re : phasor_re_q;
      s.im   = fixed ? fix_im : phasor_im_q;
      s.last = (k == n - 1);
      expected_samples.push_back(s);
      nr = clamp_word(qmul(phasor_re_q, rate_re_q) - qmul(phasor_im_q, rate_im_q));
      ni = clamp_word(qmul(phasor_re_q, rate_im_q) + qmul(phasor_im_q, rate_re_q));
      phasor_re_q = nr;
      phasor_im_q = ni;
      if (renorm_due) begin
        mag = qmul(phasor_re_q, phasor_re_q) + qmul(phasor_im_q, phasor_im_q);
        d   = clamp_word((THREE_FIX - mag) >>> 1);
        phasor_re_q = clamp_word(qmul(phasor_re_q, d));
        phasor_im_q = clamp_word(qmul(phasor_im_q, d));
      end
      renorm_due = !renorm_due;
    end
  endfunction

  // Offer one request; return at the falling edge after the transfer, valid still high
  task automatic offer_burst(input logic [COUNT_W-1:0] count, input bit fixed,
                             input word_t fix_re, input word_t fix_im);
    in_ch.valid        <= 1'b1;
    in_ch.sample_count <= count;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_tone_burst(count, fixed, fix_re, fix_im);
    @(negedge clk);
  endtask

  // Drop the request and hold until every predicted sample has been seen
  task automatic drain;
    in_ch.valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Write a register, then read it back
  task automatic write_reg(input reg_idx_t sel, input word_t v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    apply_write(sel, v);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== v) begin
      reg_errors++;
      $display("%0t: register %s read back expected %h got %h", $time, sel.name(), v, prdata);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    // leave the port idle between accesses
    @(negedge clk);
  endtask

  // Pick a pair of register values: mostly unit vectors, some extremes, some raw words
  task automatic pick_pair(output word_t a, output word_t b);
    real ang;
    int  mode;
    word_t corners[5];
    corners = '{UNIT_Q, NEG_UNIT_Q, 32'sd0, MAX_Q, MIN_Q};
    mode = $urandom_range(0, 99);
    if (mode < 70) begin
      ang = 6.283185307 * $urandom_range(0, 99999) / 100000.0;
      a   = word_t'($rtoi($cos(ang) * 1073741824.0));
      b   = word_t'($rtoi($sin(ang) * 1073741824.0));
    end else if (mode < 85) begin
      a = corners[$urandom_range(0, 4)];
      b = corners[$urandom_range(0, 4)];
    end else begin
      a = word_t'($urandom);
      b = word_t'($urandom);
    end
  endtask

  function automatic logic [COUNT_W-1:0] pick_count;
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 60) return COUNT_W'($urandom_range(1, 8));
    if (r < 85) return COUNT_W'($urandom_range(9, 63));
    return COUNT_W'($urandom_range(64, 127));
  endfunction

  // Result side ready: random stall bursts, quiet stretches, and one long hold-off
  always @(negedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      rx_stall = LONG_HOLD;
    end
    if (rx_stall > 0) begin
      rx_stall--;
      out_ch.ready <= 1'b0;
    end else if (calm || rx_quiet > 0) begin
      if (rx_quiet > 0) rx_quiet--;
      out_ch.ready <= 1'b1;
    end else if ($urandom_range(0, 99) < 3) begin
      rx_quiet = $urandom_range(40, 200);
      out_ch.ready <= 1'b1;
    end else if ($urandom_range(0, 99) < 10) begin
      rx_stall = $urandom_range(1, 12) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Compare each sample transfer with the oldest prediction
  always @(posedge clk) begin
    tone_sample_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_samples.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected sample re=%h im=%h last=%b", $time,
                 out_ch.sample_re, out_ch.sample_im, out_ch.last_sample);
      end else begin
        want = expected_samples.pop_front();
        if (out_ch.sample_re !== want.re) begin
          mismatches++;
          $display("%0t: sample_re expected %h got %h", $time, want.re, out_ch.sample_re);
        end
        if (out_ch.sample_im !== want.im) begin
          mismatches++;
          $display("%0t: sample_im expected %h got %h", $time, want.im, out_ch.sample_im);
        end
        if (out_ch.last_sample !== want.last) begin
          mismatches++;
          $display("%0t: last_sample expected %b got %b", $time, want.last,
                   out_ch.last_sample);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    word_t a, b;
    int    pause_at;

    rst_n              = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    in_ch.valid        = 1'b0;
    in_ch.sample_count = '0;
    out_ch.ready       = 1'b0;
    mismatches         = 0;
    reg_errors         = 0;
    cycle_count        = 0;
    calm               = 1'b0;
    hold_req           = 0;
    hold_ack           = 0;
    rx_stall           = 0;
    rx_quiet           = 0;

    rate_re_q   = UNIT_Q;
    rate_im_q   = '0;
    init_re_q   = UNIT_Q;
    init_im_q   = '0;
    phasor_re_q = UNIT_Q;
    phasor_im_q = '0;
    renorm_due  = 1'b0;

    // Directed plan: reset values first, then rotations, saturation and re-init
    plan.push_back('{ROW_BURST, REG_RATE_RE, 32'sd0, 7'd1, 1'b1, UNIT_Q, 32'sd0});
    plan.push_back('{ROW_BURST, REG_RATE_RE, 32'sd0, 7'd0, 1'b1, UNIT_Q, 32'sd0});
    plan.push_back('{ROW_BURST, REG_RATE_RE, 32'sd0, 7'd64, 1'b1, UNIT_Q, 32'sd0});
    plan.push_back('{ROW_BURST, REG_RATE_RE, 32'sd0, 7'd127, 1'b1, UNIT_Q, 32'sd0});
    plan.push_back('{ROW_BURST, REG_RATE_RE, 32'sd0, 7'd2, 1'b1, UNIT_Q, 32'sd0});
    // quarter turn per sample, parity carried over
    plan.push_back('{ROW_WRITE, REG_RATE_RE, 32'sd0, 7'd0, 1'b0, 32'sd0, 32'sd0});
    plan.push_back('{ROW_WRITE, REG_RATE_IM, UNIT_Q, 7'd0, 1'b0, 32'sd0, 32'sd0});
    plan.push_back('{ROW_BURST, REG_RATE_RE, 32'sd0, 7'd5, 1'b0, 32'sd0, 32'sd0});
    plan.push_back('{ROW_BURST, REG_RATE_RE, 32'sd0, 7'd3, 1'b0, 32'sd0, 32'sd0});
    // everything at the positive limit
    plan.push_back('{ROW_WRITE, REG_INIT_RE, MAX_Q, 7'd0, 1'b0, 32'sd0, 32'sd0});
    plan.push_back('{ROW_WRITE, REG_INIT_IM, MAX_Q, 7'd0, 1'b0, 32'sd0, 32'sd0});
    plan.push_back('{ROW_WRITE, REG_RATE_RE, MAX_Q, 7'd0, 1'b0, 32'sd0, 32'sd0});
    plan.push_back('{ROW_WRITE, REG_RATE_IM, MAX_Q, 7'd0, 1'b0, 32'sd0, 32'sd0});
    plan.push_back('{ROW_BURST, REG_RATE_RE, 32'sd0, 7'd6, 1'b0, 32'sd0, 32'sd0});
    // everything at the negative limit
    plan.push_back('{ROW_WRITE, REG_RATE_RE, MIN_Q, 7'd0, 1'b0, 32'sd0, 32'sd0});
    plan.push_back('{ROW_WRITE, REG_RATE_IM, MIN_Q, 7'd0, 1'b0, 32'sd0, 32'sd0});
    plan.push_back('{ROW_WRITE, REG_INIT_RE, MIN_Q, 7'd0, 1'b0, 32'sd0, 32'sd0});
    plan.push_back('{ROW_WRITE, REG_INIT_IM, MIN_Q, 7'd0, 1'b0, 32'sd0, 32'sd0});
    plan.push_back('{ROW_BURST, REG_RATE_RE, 32'sd0, 7'd6, 1'b0, 32'sd0, 32'sd0});
    // zero phasor stays zero
    plan.push_back('{ROW_WRITE, REG_INIT_RE, 32'sd0, 7'd0, 1'b0, 32'sd0, 32'sd0});
    plan.push_back('{ROW_WRITE, REG_INIT_IM, 32'sd0, 7'd0, 1'b0, 32'sd0, 32'sd0});
    plan.push_back('{ROW_BURST, REG_RATE_RE, 32'sd0, 7'd9, 1'b1, 32'sd0, 32'sd0});
    // zero rate collapses the phasor after one sample
    plan.push_back('{ROW_WRITE, REG_RATE_RE, 32'sd0, 7'd0, 1'b0, 32'sd0, 32'sd0});
    plan.push_back('{ROW_WRITE, REG_RATE_IM, 32'sd0, 7'd0, 1'b0, 32'sd0, 32'sd0});
    plan.push_back('{ROW_WRITE, REG_INIT_RE, UNIT_Q, 7'd0, 1'b0, 32'sd0, 32'sd0});
    plan.push_back('{ROW_BURST, REG_RATE_RE, 32'sd0, 7'd4, 1'b0, 32'sd0, 32'sd0});
    // half turn from an oversized start vector, then re-init clears parity
    plan.push_back('{ROW_WRITE, REG_RATE_RE, NEG_UNIT_Q, 7'd0, 1'b0, 32'sd0, 32'sd0});
    plan.push_back('{ROW_WRITE, REG_INIT_IM, NEG_UNIT_Q, 7'd0, 1'b0, 32'sd0, 32'sd0});
    plan.push_back('{ROW_BURST, REG_RATE_RE, 32'sd0, 7'd7, 1'b0, 32'sd0, 32'sd0});
    plan.push_back('{ROW_WRITE, REG_INIT_IM, 32'sd0, 7'd0, 1'b0, 32'sd0, 32'sd0});
    plan.push_back('{ROW_BURST, REG_RATE_RE, 32'sd0, 7'd1, 1'b0, 32'sd0, 32'sd0});
    plan.push_back('{ROW_BURST, REG_RATE_RE, 32'sd0, 7'd1, 1'b0, 32'sd0, 32'sd0});
    plan.push_back('{ROW_BURST, REG_RATE_RE, 32'sd0, 7'd16, 1'b0, 32'sd0, 32'sd0});
    plan.push_back('{ROW_BURST, REG_RATE_RE, 32'sd0, 7'd33, 1'b0, 32'sd0, 32'sd0});
    plan.push_back('{ROW_BURST, REG_RATE_RE, 32'sd0, 7'd65, 1'b0, 32'sd0, 32'sd0});
    plan.push_back('{ROW_BURST, REG_RATE_RE, 32'sd0, 7'd96, 1'b0, 32'sd0, 32'sd0});

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Walk the directed plan; settle the block before each register write
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        write_reg(plan[i].reg_sel, plan[i].wdata);
      end else begin
        offer_burst(plan[i].count, plan[i].fixed, plan[i].fix_re, plan[i].fix_im);
      end
    end

    // Random phases after random register writes; the last one has no random idles
    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      repeat (SETTLE_CYCLES) @(negedge clk);
      calm = (phase == PHASES - 1);
      pick_pair(a, b);
      if (phase == 0 || $urandom_range(0, 1)) write_reg(REG_RATE_RE, a);
      if (phase == 0 || $urandom_range(0, 1)) write_reg(REG_RATE_IM, b);
      pick_pair(a, b);
      if (phase == 0 || $urandom_range(0, 1)) write_reg(REG_INIT_RE, a);
      if (phase == 0 || $urandom_range(0, 1)) write_reg(REG_INIT_IM, b);
      // hold off the result side long enough to back up the request side
      if (phase == 2) hold_req++;
      pause_at = $urandom_range(5, PHASE_ITEMS - 5);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == pause_at) drain();
        else if (!calm && $urandom_range(0, 99) < 25) begin
          in_ch.valid <= 1'b0;
          repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        offer_burst(pick_count(), 1'b0, 32'sd0, 32'sd0);
      end
    end

    in_ch.valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0 && reg_errors == 0 && expected_samples.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/cptg_pkg.sv
hw/rtl/cptg_channels.sv
hw/rtl/cptg_regs.sv
hw/rtl/cptg_ctrl.sv
hw/rtl/cptg_dp.sv
hw/rtl/complex_phasor_tone_generator_unit.sv
verif/tb_complex_phasor_tone_generator_unit.sv
